// File: hdl/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg
// shared types, constants and the microcode rom of the cassette block framer
// ----------------------------------------------------------------------------
package cbf_pkg;

	// framing sizes
	localparam int BLOCK_BYTES  = 255;
	localparam int LEADER_BYTES = 256;
	localparam int LEAD_FULL    = LEADER_BYTES / 8;
	localparam int LEAD_REM     = LEADER_BYTES % 8;

	localparam logic [63:0] LEAD_WORD     = 64'h5555_5555_5555_5555;
	localparam logic [63:0] LEAD_REM_WORD = LEAD_WORD >> (8 * (8 - LEAD_REM));

	localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
	localparam int IDX_W  = (FILL_W > 3) ? FILL_W : 3;
	localparam int RAM_AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

	// frame bytes
	localparam logic [7:0] BYTE_SYNC     = 8'h55;
	localparam logic [7:0] BYTE_MARK     = 8'h3C;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] BYTE_NAME_LEN = 8'h0F;
	localparam logic [7:0] BYTE_EXEC     = 8'h02;
	localparam logic [7:0] BYTE_DATA_TYP = 8'h01;
	localparam logic [7:0] BYTE_END_TYP  = 8'hFF;
	localparam logic [7:0] BYTE_PAD      = 8'h20;

	localparam logic [2:0] NAME_LAST = 3'd7;

	// item commands
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// register indexes
	localparam logic [1:0] REG_LOAD  = 2'd0;
	localparam logic [1:0] REG_START = 2'd1;
	localparam logic [1:0] REG_NAME  = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} cbf_item_t;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  byte_count;
		logic [5:0]  repeat_res;
		logic        last;
	} cbf_res_t;

	typedef struct packed {
		logic [15:0] load_address;
		logic [15:0] start_address;
		logic [63:0] name_chars;
	} cbf_cfg_t;

	typedef enum logic [3:0] {
		SRC_SYNC, SRC_MARK, SRC_ZERO, SRC_NAMELEN, SRC_EXEC, SRC_ONE, SRC_FF,
		SRC_NAME, SRC_STH, SRC_STL, SRC_LDH, SRC_LDL, SRC_CHK, SRC_FILL, SRC_RAM
	} src_t;

	typedef enum logic [1:0] {LEAD_NONE, LEAD_GRP, LEAD_TAIL} lead_t;

	typedef enum logic [1:0] {LAST_NEVER, LAST_ALWAYS, LAST_HDR, LAST_DATA} last_t;

	typedef enum logic [1:0] {IDX_HOLD, IDX_CLR, IDX_INC} idx_op_t;

	typedef enum logic [3:0] {
		C_NEXT, C_ALWAYS, C_NO_ITEM, C_FIN, C_HDR, C_CMD_END, C_NO_BLOCK,
		C_FILL_ZERO, C_NAME_MORE, C_DATA_MORE
	} cond_t;

	typedef logic [5:0] step_t;

	// branch targets
	localparam step_t S_IDLE  = 6'd0;
	localparam step_t S_NAME  = 6'd9;
	localparam step_t S_DATA  = 6'd21;
	localparam step_t S_BLOCK = 6'd23;
	localparam step_t S_BODY  = 6'd27;
	localparam step_t S_END   = 6'd31;
	localparam step_t S_ENDF  = 6'd33;

	typedef struct packed {
		logic    accept;
		logic    push;
		logic    eof;
		logic    sum_en;
		logic    ck_clr;
		logic    ram_wr;
		logic    ram_rd;
		logic    hdr_set;
		logic    fin_set;
		logic    blk_clr;
		src_t    src;
		lead_t   lead;
		last_t   last;
		idx_op_t idx_op;
		cond_t   cond;
		step_t   target;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic stall;
		logic fin;
		logic hdr;
		logic cmd_end;
		logic no_block;
		logic fill_zero;
		logic name_more;
		logic data_more;
	} stat_t;

	localparam ctl_t CW_NOP = '{
		accept: 1'b0, push: 1'b0, eof: 1'b0, sum_en: 1'b0, ck_clr: 1'b0,
		ram_wr: 1'b0, ram_rd: 1'b0, hdr_set: 1'b0, fin_set: 1'b0, blk_clr: 1'b0,
		src: SRC_SYNC, lead: LEAD_NONE, last: LAST_NEVER, idx_op: IDX_HOLD,
		cond: C_NEXT, target: S_IDLE
	};

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61) ? c - 8'h20 : c;
	endfunction

	// microcode rom, one control word per step
	function automatic ctl_t ucode(input step_t s);
		ctl_t w;
		w = CW_NOP;
		case (s)
			// wait for an item
			6'd0: begin
				w.accept = 1'b1; w.cond = C_NO_ITEM; w.target = S_IDLE;
			end
			6'd1: begin w.cond = C_FIN; w.target = S_IDLE; end
			6'd2: begin w.cond = C_HDR; w.target = S_DATA; end
			// first leader
			6'd3: begin w.lead = LEAD_GRP; w.hdr_set = 1'b1; end
			6'd4: begin w.lead = LEAD_TAIL; end
			// name block
			6'd5: begin w.push = 1'b1; w.src = SRC_SYNC; w.ck_clr = 1'b1; end
			6'd6: begin w.push = 1'b1; w.src = SRC_MARK; end
			6'd7: begin w.push = 1'b1; w.src = SRC_ZERO; w.sum_en = 1'b1; end
			6'd8: begin
				w.push = 1'b1; w.src = SRC_NAMELEN; w.sum_en = 1'b1; w.idx_op = IDX_CLR;
			end
			6'd9: begin
				w.push = 1'b1; w.src = SRC_NAME; w.sum_en = 1'b1; w.idx_op = IDX_INC;
				w.cond = C_NAME_MORE; w.target = S_NAME;
			end
			6'd10: begin w.push = 1'b1; w.src = SRC_EXEC; w.sum_en = 1'b1; end
			6'd11: begin w.push = 1'b1; w.src = SRC_ZERO; w.sum_en = 1'b1; end
			6'd12: begin w.push = 1'b1; w.src = SRC_ZERO; w.sum_en = 1'b1; end
			6'd13: begin w.push = 1'b1; w.src = SRC_STH; w.sum_en = 1'b1; end
			6'd14: begin w.push = 1'b1; w.src = SRC_STL; w.sum_en = 1'b1; end
			6'd15: begin w.push = 1'b1; w.src = SRC_LDH; w.sum_en = 1'b1; end
			6'd16: begin w.push = 1'b1; w.src = SRC_LDL; w.sum_en = 1'b1; end
			6'd17: begin w.push = 1'b1; w.src = SRC_CHK; end
			6'd18: begin w.push = 1'b1; w.src = SRC_SYNC; w.eof = 1'b1; end
			// second leader
			6'd19: begin w.lead = LEAD_GRP; w.last = LAST_HDR; end
			6'd20: begin w.lead = LEAD_TAIL; w.last = LAST_HDR; end
			// data byte or end of stream
			6'd21: begin w.cond = C_CMD_END; w.target = S_END; end
			6'd22: begin w.ram_wr = 1'b1; w.cond = C_NO_BLOCK; w.target = S_IDLE; end
			// data block
			6'd23: begin w.push = 1'b1; w.src = SRC_SYNC; w.ck_clr = 1'b1; end
			6'd24: begin w.push = 1'b1; w.src = SRC_MARK; end
			6'd25: begin w.push = 1'b1; w.src = SRC_ONE; w.sum_en = 1'b1; end
			6'd26: begin
				w.push = 1'b1; w.src = SRC_FILL; w.sum_en = 1'b1;
				w.idx_op = IDX_CLR; w.ram_rd = 1'b1;
			end
			6'd27: begin
				w.push = 1'b1; w.src = SRC_RAM; w.sum_en = 1'b1; w.idx_op = IDX_INC;
				w.ram_rd = 1'b1; w.cond = C_DATA_MORE; w.target = S_BODY;
			end
			6'd28: begin w.push = 1'b1; w.src = SRC_CHK; end
			6'd29: begin
				w.push = 1'b1; w.src = SRC_SYNC; w.eof = 1'b1; w.last = LAST_DATA;
				w.blk_clr = 1'b1; w.cond = C_CMD_END; w.target = S_ENDF;
			end
			6'd30: begin w.cond = C_ALWAYS; w.target = S_IDLE; end
			// end of stream
			6'd31: begin w.cond = C_FILL_ZERO; w.target = S_ENDF; end
			6'd32: begin w.cond = C_ALWAYS; w.target = S_BLOCK; end
			6'd33: begin w.push = 1'b1; w.src = SRC_SYNC; end
			6'd34: begin w.push = 1'b1; w.src = SRC_MARK; end
			6'd35: begin w.push = 1'b1; w.src = SRC_FF; end
			6'd36: begin w.push = 1'b1; w.src = SRC_ZERO; end
			6'd37: begin w.push = 1'b1; w.src = SRC_FF; end
			6'd38: begin
				w.push = 1'b1; w.src = SRC_SYNC; w.eof = 1'b1; w.last = LAST_ALWAYS;
				w.fin_set = 1'b1; w.cond = C_ALWAYS; w.target = S_IDLE;
			end
			default: begin w.cond = C_ALWAYS; w.target = S_IDLE; end
		endcase
		return w;
	endfunction

endpackage

// File: hdl/cbf_ram.sv
// ----------------------------------------------------------------------------
// cbf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/cbf_seq.sv
// ----------------------------------------------------------------------------
// cbf_seq
// step counter and rom decode of the framer microcode
// ----------------------------------------------------------------------------
module cbf_seq import cbf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	step_t step_q;
	step_t step_nxt;
	logic  take;

	assign ctl = ucode(step_q);

	always_comb begin
		unique case (ctl.cond)
			C_NEXT:      take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_ITEM:   take = !stat.in_valid;
			C_FIN:       take = stat.fin;
			C_HDR:       take = stat.hdr;
			C_CMD_END:   take = stat.cmd_end;
			C_NO_BLOCK:  take = stat.no_block;
			C_FILL_ZERO: take = stat.fill_zero;
			C_NAME_MORE: take = stat.name_more;
			C_DATA_MORE: take = stat.data_more;
			default:     take = 1'b0;
		endcase
	end

	always_comb begin
		if (stat.stall) begin
			step_nxt = step_q;
		end else if (take) begin
			step_nxt = ctl.target;
		end else begin
			step_nxt = step_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

// File: hdl/cbf_dp.sv
// ----------------------------------------------------------------------------
// cbf_dp
// framer datapath: byte select, checksum, block buffer, byte packer, result register
// ----------------------------------------------------------------------------
module cbf_dp import cbf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_t      ctl,
	input  cbf_cfg_t  cfg,
	input  logic      item_valid,
	input  cbf_item_t item,
	output stat_t     stat,
	output logic      res_valid,
	input  logic      res_ready,
	output cbf_res_t  res
);

	cbf_item_t            item_q;
	logic [FILL_W-1:0]    fill_q;
	logic [IDX_W-1:0]     idx_q;
	logic [7:0]           ck_q;
	logic                 hdr_q;
	logic                 fin_q;
	logic                 go_q;
	logic [63:0]          pack_q;
	logic [2:0]           pcnt_q;
	logic                 res_valid_q;
	cbf_res_t             res_q;

	logic [7:0]           nm_c;
	logic                 nm_ok;
	logic [7:0]           b;
	logic [7:0]           ram_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 rd_en;
	logic                 wr_en;
	logic [3:0]           cnt_nxt;
	logic [63:0]          pack_nxt;
	logic                 emit_push;
	logic                 lead_grp_on;
	logic                 lead_tail_on;
	logic                 emit;
	logic                 stall;
	logic                 adv;
	logic                 no_block;
	logic                 last_raw;
	cbf_res_t             res_nxt;

	// name character with prefix cut and uppercase
	assign nm_c  = cfg.name_chars[{idx_q[2:0], 3'b000} +: 8];
	assign nm_ok = go_q && is_alnum(nm_c);

	assign no_block = ((FILL_W+1)'(fill_q) + (FILL_W+1)'(1)) < (FILL_W+1)'(BLOCK_BYTES);

	always_comb begin
		case (ctl.src)
			SRC_SYNC:    b = BYTE_SYNC;
			SRC_MARK:    b = BYTE_MARK;
			SRC_ZERO:    b = BYTE_ZERO;
			SRC_NAMELEN: b = BYTE_NAME_LEN;
			SRC_EXEC:    b = BYTE_EXEC;
			SRC_ONE:     b = BYTE_DATA_TYP;
			SRC_FF:      b = BYTE_END_TYP;
			SRC_NAME:    b = nm_ok ? to_upper(nm_c) : BYTE_PAD;
			SRC_STH:     b = cfg.start_address[15:8];
			SRC_STL:     b = cfg.start_address[7:0];
			SRC_LDH:     b = cfg.load_address[15:8];
			SRC_LDL:     b = cfg.load_address[7:0];
			SRC_CHK:     b = ck_q;
			SRC_FILL:    b = 8'(fill_q);
			SRC_RAM:     b = ram_q;
			default:     b = BYTE_SYNC;
		endcase
	end

	// packer
	assign cnt_nxt   = {1'b0, pcnt_q} + 4'd1;
	assign pack_nxt  = pack_q | ({56'd0, b} << {pcnt_q, 3'b000});
	assign emit_push = ctl.push && (ctl.eof || cnt_nxt == 4'd8);

	assign lead_grp_on  = (ctl.lead == LEAD_GRP) && (LEAD_FULL != 0);
	assign lead_tail_on = (ctl.lead == LEAD_TAIL) && (LEAD_REM != 0);
	assign emit         = emit_push || lead_grp_on || lead_tail_on;

	assign stall = emit && res_valid_q && !res_ready;
	assign adv   = !stall;

	always_comb begin
		case (ctl.last)
			LAST_NEVER:  last_raw = 1'b0;
			LAST_ALWAYS: last_raw = 1'b1;
			LAST_HDR:    last_raw = (item_q.cmd == CMD_DATA) && no_block;
			LAST_DATA:   last_raw = (item_q.cmd == CMD_DATA);
			default:     last_raw = 1'b0;
		endcase
	end

	always_comb begin
		if (lead_grp_on) begin
			res_nxt.out_bytes  = LEAD_WORD;
			res_nxt.byte_count = 4'd8;
			res_nxt.repeat_res = 6'(LEAD_FULL);
			res_nxt.last       = last_raw && (LEAD_REM == 0);
		end else if (lead_tail_on) begin
			res_nxt.out_bytes  = LEAD_REM_WORD;
			res_nxt.byte_count = 4'(LEAD_REM);
			res_nxt.repeat_res = 6'd1;
			res_nxt.last       = last_raw;
		end else begin
			res_nxt.out_bytes  = pack_nxt;
			res_nxt.byte_count = cnt_nxt;
			res_nxt.repeat_res = 6'd1;
			res_nxt.last       = last_raw;
		end
	end

	// block buffer
	assign rd_addr = (ctl.idx_op == IDX_CLR) ? '0 : idx_q + IDX_W'(1);
	assign rd_en   = adv && ctl.ram_rd && (rd_addr < IDX_W'(fill_q));
	assign wr_en   = adv && ctl.ram_wr;

	cbf_ram #(
		.WIDTH (8),
		.DEPTH (BLOCK_BYTES)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[RAM_AW-1:0]),
		.wr_data (item_q.data_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr[RAM_AW-1:0]),
		.rd_data (ram_q)
	);

	always_ff @(posedge clk) begin
		if (item_valid && ctl.accept) begin
			item_q <= item;
		end
		if (adv && emit) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			idx_q       <= '0;
			ck_q        <= '0;
			hdr_q       <= 1'b0;
			fin_q       <= 1'b0;
			go_q        <= 1'b0;
			pack_q      <= '0;
			pcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv && emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (adv) begin
				if (ctl.push) begin
					if (emit_push) begin
						pack_q <= '0;
						pcnt_q <= '0;
					end else begin
						pack_q <= pack_nxt;
						pcnt_q <= pcnt_q + 3'd1;
					end
				end
				if (ctl.ck_clr) begin
					ck_q <= '0;
					go_q <= 1'b1;
				end else if (ctl.push && ctl.sum_en) begin
					ck_q <= ck_q + b;
				end
				if (ctl.push && ctl.src == SRC_NAME && !nm_ok) begin
					go_q <= 1'b0;
				end
				unique case (ctl.idx_op)
					IDX_CLR:  idx_q <= '0;
					IDX_INC:  idx_q <= idx_q + IDX_W'(1);
					default:  idx_q <= idx_q;
				endcase
				if (ctl.ram_wr) begin
					fill_q <= fill_q + FILL_W'(1);
				end else if (ctl.blk_clr) begin
					fill_q <= '0;
				end
				if (ctl.hdr_set) begin
					hdr_q <= 1'b1;
				end
				if (ctl.fin_set) begin
					fin_q <= 1'b1;
				end
			end
		end
	end

	assign stat.in_valid  = item_valid;
	assign stat.stall     = stall;
	assign stat.fin       = fin_q;
	assign stat.hdr       = hdr_q;
	assign stat.cmd_end   = (item_q.cmd == CMD_END);
	assign stat.no_block  = no_block;
	assign stat.fill_zero = (fill_q == '0);
	assign stat.name_more = (idx_q[2:0] != NAME_LAST);
	assign stat.data_more = ((IDX_W+1)'(idx_q) + (IDX_W+1)'(1)) < (IDX_W+1)'(fill_q);

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: hdl/cassette_block_framer_core.sv
// ----------------------------------------------------------------------------
// cassette_block_framer_core
// frames a byte stream into a cassette tape image with checksummed blocks
// ----------------------------------------------------------------------------
// The first item of either kind sends a 0x55 leader, the name block and a
// second leader; data bytes are collected in a 255-byte buffer and leave as
// 55 3C 01 len data chk 55 when the buffer fills; an end command flushes any
// partial block, sends 55 3C FF 00 FF 55, and every later item is dropped.
// Results are groups of up to eight bytes, first byte in the low bits; a
// leader is one group of eight 0x55 with a repeat count. The block takes one
// item at a time: a data byte that closes no block holds item_ready low
// while the program steps back to idle, a block flush adds the frame of that
// block, the first item adds the header, and the end command holds it low
// while its own frame and any flush go out. The microcode sequencer moves one
// frame byte per cycle into the packer unless a result waits on res_ready,
// and it reads the buffer through a single read port.
// Configuration writes are taken at any time but belong in idle periods; the
// name and addresses are sampled while the header goes out.
// ----------------------------------------------------------------------------
module cassette_block_framer_core import cbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_ready,
	input  cbf_item_t   item,
	// result channel
	output logic        res_valid,
	input  logic        res_ready,
	output cbf_res_t    res,
	// configuration writes
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data
);

	cbf_cfg_t cfg_q;
	ctl_t     ctl;
	stat_t    stat;

	// configuration registers, writes beyond the list fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_LOAD:  cfg_q.load_address  <= wr_data[15:0];
				REG_START: cfg_q.start_address <= wr_data[15:0];
				REG_NAME:  cfg_q.name_chars    <= wr_data;
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	// items are taken only on the idle step of the program
	assign item_ready = ctl.accept;

	cbf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	cbf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.stat       (stat),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

`ifndef SYNTHESIS
	// one item per pass through the program
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("item_ready stayed high after a transfer");

	// every result carries one to eight bytes
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.byte_count != 4'd0 && res.byte_count <= 4'd8))
		else $error("result byte count out of range");

	// only full leader groups repeat
	a_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.repeat_res != 6'd1) |->
			(res.byte_count == 4'd8 && res.out_bytes == LEAD_WORD))
		else $error("repeated group is not a full leader group");

	// a result still waiting on res_ready stays valid while the block is idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(item_ready && res_valid && !res_ready) |=> res_valid)
		else $error("waiting result dropped while idle");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for cassette_block_framer_core
// ----------------------------------------------------------------------------
// Drives a single byte stream through the framer: a directed run of edge
// bytes, random bytes under several idle and stall mixes, a long receiver
// hold-off across a block flush, and the end command followed by items the
// block must drop. An in-bench model of the framing predicts every result
// group, and each group that leaves the block is compared field by field.
// Configuration writes happen only while the block is idle.
// ----------------------------------------------------------------------------
module tb import cbf_pkg::*; ();

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 40;
	localparam int HOLD_CYCLES   = 600;
	localparam int HOLD_ITEMS    = 10;

	// bytes that sit on field boundaries or look like frame bytes
	localparam logic [7:0] EDGE_BYTES [12] = '{
		8'h00, 8'hFF, 8'h55, 8'h3C, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h20, 8'hAA,
		8'h0F, 8'h02
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	cbf_item_t   item = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	cbf_res_t    res;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = REG_LOAD;
	logic [63:0] wr_data = '0;

	// stimulus knobs
	int   send_gap_pct = 0;
	int   rx_stall_pct = 0;
	logic rx_hold = 1'b0;
	int   sent_bytes = 0;

	// framing model state
	cbf_cfg_t    cfg_shadow = '0;
	logic [7:0]  blk_store [BLOCK_BYTES];
	int          blk_fill = 0;
	logic [7:0]  blk_sum = '0;
	logic        hdr_sent = 1'b0;
	logic        stream_done = 1'b0;
	logic [7:0]  frame_bytes [$];
	cbf_res_t    item_groups [$];
	cbf_res_t    pending_groups [$];

	int          err_cnt = 0;
	int unsigned cycle_cnt = 0;

	cassette_block_framer_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// framing model
	// ------------------------------------------------------------------------

	task automatic push_group(input logic [63:0] w, input int cnt, input int rep);
		item_groups.push_back(cbf_res_t'{out_bytes: w, byte_count: 4'(cnt),
			repeat_res: 6'(rep), last: 1'b0});
	endtask

	// cut the frame into groups of up to eight bytes, first byte lowest
	task automatic pack_frame();
		logic [63:0] w;
		int k;
		while (frame_bytes.size() != 0) begin
			w = '0;
			k = 0;
			while (k < 8 && frame_bytes.size() != 0) begin
				w[8*k +: 8] = frame_bytes.pop_front();
				k++;
			end
			push_group(w, k, 1);
		end
	endtask

	// a leader is one repeated group of eight sync bytes plus any odd tail
	task automatic push_leader();
		logic [63:0] w;
		w = '0;
		if (LEADER_BYTES / 8 > 0)
			push_group({8{BYTE_SYNC}}, 8, LEADER_BYTES / 8);
		if (LEADER_BYTES % 8 > 0) begin
			for (int k = 0; k < LEADER_BYTES % 8; k++)
				w[8*k +: 8] = BYTE_SYNC;
			push_group(w, LEADER_BYTES % 8, 1);
		end
	endtask

	task automatic frame_header();
		logic [7:0] c;
		logic       going;
		logic [7:0] chk;
		push_leader();
		frame_bytes = {BYTE_SYNC, BYTE_MARK, BYTE_ZERO, BYTE_NAME_LEN};
		going = 1'b1;
		// name runs over leading alphanumerics, uppercased, then space padded
		for (int i = 0; i < 8; i++) begin
			c = cfg_shadow.name_chars[8*i +: 8];
			if (going && ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
					(c >= 8'h61 && c <= 8'h7A))) begin
				frame_bytes.push_back((c >= 8'h61) ? c - 8'h20 : c);
			end else begin
				going = 1'b0;
				frame_bytes.push_back(BYTE_PAD);
			end
		end
		frame_bytes.push_back(BYTE_EXEC);
		frame_bytes.push_back(BYTE_ZERO);
		frame_bytes.push_back(BYTE_ZERO);
		frame_bytes.push_back(cfg_shadow.start_address[15:8]);
		frame_bytes.push_back(cfg_shadow.start_address[7:0]);
		frame_bytes.push_back(cfg_shadow.load_address[15:8]);
		frame_bytes.push_back(cfg_shadow.load_address[7:0]);
		chk = '0;
		for (int i = 2; i < 19; i++)
			chk += frame_bytes[i];
		frame_bytes.push_back(chk);
		frame_bytes.push_back(BYTE_SYNC);
		pack_frame();
		push_leader();
	endtask

	task automatic frame_block();
		frame_bytes = {BYTE_SYNC, BYTE_MARK, BYTE_DATA_TYP, 8'(blk_fill)};
		for (int i = 0; i < blk_fill; i++)
			frame_bytes.push_back(blk_store[i]);
		frame_bytes.push_back(BYTE_DATA_TYP + 8'(blk_fill) + blk_sum);
		frame_bytes.push_back(BYTE_SYNC);
		pack_frame();
		blk_fill = 0;
		blk_sum = '0;
	endtask

	// expected groups for one accepted item
	task automatic frame_item(input cbf_item_t it);
		if (!stream_done) begin
			item_groups.delete();
			if (!hdr_sent) begin
				frame_header();
				hdr_sent = 1'b1;
			end
			if (it.cmd == CMD_DATA) begin
				blk_store[blk_fill] = it.data_byte;
				blk_fill++;
				blk_sum += it.data_byte;
				if (blk_fill >= BLOCK_BYTES)
					frame_block();
			end else begin
				if (blk_fill > 0)
					frame_block();
				frame_bytes = {BYTE_SYNC, BYTE_MARK, BYTE_END_TYP, BYTE_ZERO, BYTE_END_TYP,
					BYTE_SYNC};
				pack_frame();
				stream_done = 1'b1;
			end
			if (item_groups.size() != 0)
				item_groups[item_groups.size() - 1].last = 1'b1;
			foreach (item_groups[i])
				pending_groups.push_back(item_groups[i]);
		end
	endtask

	// register shadow and item transfers, both seen at the clock edge
	always @(posedge clk) begin
		if (wr_en) begin
			case (wr_index)
				REG_LOAD:  cfg_shadow.load_address  = wr_data[15:0];
				REG_START: cfg_shadow.start_address = wr_data[15:0];
				REG_NAME:  cfg_shadow.name_chars    = wr_data;
				default: ;
			endcase
		end
		if (item_valid && item_ready)
			frame_item(item);
	end

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	// random stall, or a forced hold-off while the pressure test runs
	always @(posedge clk)
		res_ready <= !rx_hold && ($urandom_range(1, 100) > rx_stall_pct);

	task automatic compare_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, fname, want, got);
			err_cnt++;
		end
	endtask

	// every result transfer is matched against the oldest expected group
	always @(posedge clk) begin : result_check
		cbf_res_t want;
		if (res_valid && res_ready) begin
			if (pending_groups.size() == 0) begin
				$display("%0t: group with nothing expected, expected none got %h", $time, res);
				err_cnt++;
			end else begin
				want = pending_groups.pop_front();
				compare_field("out_bytes", want.out_bytes, res.out_bytes);
				compare_field("byte_count", 64'(want.byte_count), 64'(res.byte_count));
				compare_field("repeat_res", 64'(want.repeat_res), 64'(res.repeat_res));
				compare_field("last", 64'(want.last), 64'(res.last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: watchdog expired with %0d groups outstanding", $time,
				pending_groups.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// one item transfer; valid stays high when the next item follows at once
	task automatic send_item(input cbf_item_t it);
		while ($urandom_range(1, 100) <= send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		if (it.cmd == CMD_DATA)
			sent_bytes++;
	endtask

	// stop offering, wait for every expected group, then let the block settle
	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_groups.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// upper pad bits of the address writes are random to exercise the mask
	task automatic write_cfg(input cbf_cfg_t c);
		logic [47:0] pad;
		pad = {48{1'($urandom_range(0, 1))}};
		wr_en <= 1'b1;
		wr_index <= REG_LOAD;
		wr_data <= {pad, c.load_address};
		@(posedge clk);
		wr_index <= REG_START;
		wr_data <= {pad, c.start_address};
		@(posedge clk);
		wr_index <= REG_NAME;
		wr_data <= c.name_chars;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_addr();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// alphanumeric prefix of random length, a terminator, then anything
	function automatic logic [63:0] rand_name();
		logic [63:0] n;
		int          nlen;
		n = {$urandom, $urandom};
		nlen = $urandom_range(0, 8);
		for (int i = 0; i < nlen; i++) begin
			case ($urandom_range(0, 2))
				0: n[8*i +: 8] = 8'h30 + 8'($urandom_range(0, 9));
				1: n[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 25));
				default: n[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 25));
			endcase
		end
		if (nlen < 8) begin
			case ($urandom_range(0, 3))
				0: n[8*nlen +: 8] = 8'h80 + 8'($urandom_range(0, 127));
				1: n[8*nlen +: 8] = 8'h2F;
				2: n[8*nlen +: 8] = 8'h60;
				default: n[8*nlen +: 8] = 8'h7B;
			endcase
		end
		return n;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// header settings, then edge bytes; the first byte brings out the header
	task automatic test_directed();
		cbf_cfg_t hdr;
		hdr.load_address = rand_addr();
		hdr.start_address = rand_addr();
		hdr.name_chars = rand_name();
		write_cfg(hdr);
		send_gap_pct = 0;
		rx_stall_pct <= 0;
		foreach (EDGE_BYTES[i])
			send_item({CMD_DATA, EDGE_BYTES[i]});
		wait_drained();
		// later writes must leave the header alone
		write_cfg('{load_address: 16'hFFFF, start_address: 16'hFFFF, name_chars: '1});
	endtask

	task automatic test_random_phase(input int gap_pct, input int stall_pct,
			input cbf_cfg_t after);
		send_gap_pct = gap_pct;
		rx_stall_pct <= stall_pct;
		repeat (PHASE_ITEMS)
			send_item({CMD_DATA, 8'($urandom_range(0, 255))});
		wait_drained();
		write_cfg(after);
	endtask

	// hold the receiver across a block flush so the input side backs up
	task automatic test_backpressure();
		send_gap_pct = 0;
		rx_stall_pct <= 0;
		while (sent_bytes % BLOCK_BYTES != BLOCK_BYTES - 8)
			send_item({CMD_DATA, 8'($urandom_range(0, 255))});
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (HOLD_ITEMS)
			send_item({CMD_DATA, 8'($urandom_range(0, 255))});
		wait_drained();
	endtask

	// either an end right away or a short run of data bytes first,
	// then a few items that must be dropped
	task automatic test_end_of_stream();
		int tail;
		send_gap_pct = 20;
		rx_stall_pct <= 20;
		tail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
		repeat (tail)
			send_item({CMD_DATA, 8'($urandom_range(0, 255))});
		send_item({CMD_END, 8'($urandom_range(0, 255))});
		repeat (4)
			send_item({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(0, 0, '0);
		test_random_phase(84, 0, '{load_address: 16'hFFFF, start_address: 16'h0000,
			name_chars: '1});
		test_random_phase(0, 84, '{load_address: rand_addr(), start_address: rand_addr(),
			name_chars: rand_name()});
		test_random_phase(30, 30, '0);
		test_backpressure();
		test_end_of_stream();
		if (pending_groups.size() != 0)
			$display("%0t: %0d expected groups never arrived", $time, pending_groups.size());
		if (err_cnt == 0 && pending_groups.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
